// ===== hw/rtl/rms_pkg.sv =====
package rms_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 7;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

// ===== hw/rtl/rms_ram.sv =====
module rms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rms_alu.sv =====
// Shared add/subtract unit: compares during insertion, sums the middles afterwards.
module rms_alu #(
    parameter int WIDTH = 32
) (
    input  rms_pkg::alu_op_t   op,
    input  logic signed [WIDTH-1:0] a,
    input  logic signed [WIDTH-1:0] b,
    output logic signed [WIDTH:0]   result
);

    logic signed [WIDTH:0] a_ext;
    logic signed [WIDTH:0] b_ext;

    assign a_ext = (WIDTH+1)'(a);
    assign b_ext = (WIDTH+1)'(b);

    always_comb
    begin
        unique case (op)
            rms_pkg::ALU_SUB: result = a_ext - b_ext;
            default:          result = a_ext + b_ext;
        endcase
    end

endmodule

// ===== hw/rtl/running_median_sorted_insert.sv =====
// Running median over a stream of signed samples.
// Input s_*: one sample per transfer (low DATA_WIDTH bits used, two's complement).
// Output m_*: one result per input transfer: tdata = {held_count, median_twice},
// tuser = dropped. median_twice is the sum of the two middle entries (even count)
// or twice the middle entry (odd count).
// Samples live in a sorted RAM of CAPACITY entries. Insertion walks down from the
// top, one entry per cycle through the RAM's read port and write port, moving each
// larger entry up one slot; g is the number of held entries larger than the sample.
// Once the sample is stored (or dropped), the block reads the middle entries and
// registers their sum as the result; s_tready is high only between items, so no new
// sample is taken before that.
// A sample arriving with CAPACITY entries held is discarded, dropped is set and the
// median of the unchanged store is reported.
// Reset empties the store (fill count to zero) and clears the output valid.
// The result sits in an output register; if the receiver stalls, the next item may
// still be accepted and runs until its result would overwrite the pending one, where
// it waits for m_tready.
module running_median_sorted_insert #(
    parameter int CAPACITY   = rms_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rms_pkg::DATA_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [rms_pkg::SAMPLE_W-1:0]                s_tdata,   // [31:0] sample
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [rms_pkg::MEDIAN_W+rms_pkg::COUNT_W-1:0] m_tdata, // [32:0] median_twice,
                                                                    // [39:33] held_count
    output logic                                        m_tuser    // [0] dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_PUT  = 3'd2;
    localparam logic [2:0] ST_MED0 = 3'd3;
    localparam logic [2:0] ST_MED1 = 3'd4;
    localparam logic [2:0] ST_MED2 = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                fill_reg, fill_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic signed [DATA_WIDTH-1:0] v_reg, v_next;
    logic signed [DATA_WIDTH-1:0] a_reg, a_next;
    logic                         drop_reg, drop_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [rms_pkg::MEDIAN_W-1:0]  med_reg, med_next;
    logic [rms_pkg::COUNT_W-1:0]   cnt_reg, cnt_next;
    logic                          mdrop_reg, mdrop_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DATA_WIDTH-1:0]  wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [DATA_WIDTH-1:0]  rd_data;

    rms_pkg::alu_op_t        alu_op;
    logic signed [DATA_WIDTH-1:0] alu_b;
    logic signed [DATA_WIDTH:0]   alu_res;
    logic                    gt;
    logic [AW-1:0]           lo_addr;
    logic [AW-1:0]           hi_addr;

    rms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rms_alu #(
        .WIDTH (DATA_WIDTH)
    ) u_alu (
        .op     (alu_op),
        .a      (signed'(rd_data)),
        .b      (alu_b),
        .result (alu_res)
    );

    assign alu_op = (state_reg == ST_INS) ? rms_pkg::ALU_SUB : rms_pkg::ALU_ADD;
    assign alu_b  = (state_reg == ST_INS) ? v_reg : a_reg;
    // stored entry minus sample > 0: entry moves up one slot
    assign gt     = !alu_res[DATA_WIDTH] && (alu_res != '0);

    assign lo_addr = AW'((fill_reg - 1'b1) >> 1);
    assign hi_addr = AW'(fill_reg >> 1);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        v_next        = v_reg;
        a_next        = a_reg;
        drop_next     = drop_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        med_next      = med_reg;
        cnt_next      = cnt_reg;
        mdrop_next    = mdrop_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = v_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    v_next    = s_tdata[DATA_WIDTH-1:0];
                    drop_next = (fill_reg == CW'(CAPACITY));
                    if (fill_reg == CW'(CAPACITY))
                    begin
                        state_next = ST_MED0;
                    end
                    else if (fill_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = s_tdata[DATA_WIDTH-1:0];
                        fill_next  = fill_reg + 1'b1;
                        state_next = ST_MED0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(fill_reg - 1'b1);
                        ptr_next   = AW'(fill_reg);
                        fill_next  = fill_reg + 1'b1;
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS:
            begin
                // rd_data holds entry ptr-1
                wr_en = 1'b1;
                if (gt)
                begin
                    wr_data  = rd_data;
                    ptr_next = ptr_reg - 1'b1;
                    if (ptr_reg == AW'(1))
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ptr_reg - 1'b1 - 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_MED0;
                end
            end
            ST_PUT:
            begin
                wr_en      = 1'b1;
                state_next = ST_MED0;
            end
            ST_MED0:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_addr;
                state_next = ST_MED1;
            end
            ST_MED1:
            begin
                a_next     = rd_data;
                rd_en      = 1'b1;
                rd_addr    = hi_addr;
                state_next = ST_MED2;
            end
            ST_MED2:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    med_next      = rms_pkg::MEDIAN_W'(alu_res);
                    cnt_next      = rms_pkg::COUNT_W'(fill_reg);
                    mdrop_next    = drop_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        v_reg     <= v_next;
        a_reg     <= a_next;
        drop_reg  <= drop_next;
        med_reg   <= med_next;
        cnt_reg   <= cnt_next;
        mdrop_reg <= mdrop_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {cnt_reg, med_reg};
    assign m_tuser  = mdrop_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> (fill_reg == $past(fill_reg) + 1'b1) || drop_reg)
        else $error("accepted sample neither stored nor dropped");

    a_ins_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS |-> ptr_reg != '0)
        else $error("insertion walk at slot zero");

endmodule

// ===== bench/running_median_checker.sv =====
`timescale 1ns / 1ps

module running_median_checker #(
    parameter int CAPACITY   = rms_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rms_pkg::DATA_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    input  logic                                          s_tready,
    input  logic [rms_pkg::SAMPLE_W-1:0]                  s_tdata,   // [31:0] sample
    input  logic                                          m_tvalid,
    input  logic                                          m_tready,
    input  logic [rms_pkg::MEDIAN_W+rms_pkg::COUNT_W-1:0] m_tdata,   // [32:0] median_twice,
                                                                     // [39:33] held_count
    input  logic                                          m_tuser,   // [0] dropped
    output int                                            mismatch_count,
    output int                                            outstanding,
    output int                                            result_count,
    output int                                            drop_count
);

    typedef struct packed {
        logic [rms_pkg::MEDIAN_W-1:0] median_twice;
        logic [rms_pkg::COUNT_W-1:0]  held_count;
        logic                         dropped;
    } median_result_t;

    // Predicted contents of the sorted store, ascending
    longint         held_samples [CAPACITY];
    int             held_total;
    median_result_t expected_medians [$];

    function automatic median_result_t insert_and_median(
        input logic [rms_pkg::SAMPLE_W-1:0] raw
    );
        logic signed [rms_pkg::SAMPLE_W-1:0] aligned;
        longint                              value;
        longint                              twice;
        int                                  pos;
        median_result_t                      r;
        // keep the low DATA_WIDTH bits, sign-extended from bit DATA_WIDTH-1
        aligned = raw << (rms_pkg::SAMPLE_W - DATA_WIDTH);
        aligned = aligned >>> (rms_pkg::SAMPLE_W - DATA_WIDTH);
        value = aligned;
        r.dropped = 1'b0;
        if (held_total >= CAPACITY)
        begin
            r.dropped = 1'b1;
        end
        else
        begin
            // equal values stay ahead of the new one
            pos = 0;
            while (pos < held_total && held_samples[pos] <= value)
                pos++;
            for (int i = held_total; i > pos; i--)
                held_samples[i] = held_samples[i-1];
            held_samples[pos] = value;
            held_total++;
        end
        if (held_total % 2)
            twice = 2 * held_samples[held_total/2];
        else
            twice = held_samples[held_total/2 - 1] + held_samples[held_total/2];
        r.median_twice = twice[rms_pkg::MEDIAN_W-1:0];
        r.held_count   = held_total[rms_pkg::COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        median_result_t expected;
        if (!rst_n)
        begin
            held_total = 0;
            expected_medians.delete();
            mismatch_count = 0;
            result_count = 0;
            drop_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_medians.push_back(insert_and_median(s_tdata));
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (m_tuser === 1'b1)
                    drop_count++;
                if (expected_medians.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: tdata=%h tuser=%b",
                                 m_tdata, m_tuser);
                end
                else
                begin
                    expected = expected_medians.pop_front();
                    if (m_tdata[rms_pkg::MEDIAN_W-1:0] !== expected.median_twice ||
                        m_tdata[rms_pkg::MEDIAN_W +: rms_pkg::COUNT_W] !==
                            expected.held_count ||
                        m_tuser !== expected.dropped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result %0d: expected median_twice=%0d held=%0d dropped=%b",
                                     result_count, $signed(expected.median_twice),
                                     expected.held_count, expected.dropped);
                            $display("    got median_twice=%0d held=%0d dropped=%b",
                                     $signed(m_tdata[rms_pkg::MEDIAN_W-1:0]),
                                     m_tdata[rms_pkg::MEDIAN_W +: rms_pkg::COUNT_W],
                                     m_tuser);
                        end
                    end
                end
            end
        end
        outstanding = expected_medians.size();
    end

endmodule

// ===== bench/running_median_sorted_insert_tb.sv =====
`timescale 1ns / 1ps

module running_median_sorted_insert_tb;

    localparam int CAPACITY      = rms_pkg::CAPACITY_DEF;
    localparam int DATA_WIDTH    = rms_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int IDLE_LIMIT    = 2000;
    localparam int CORNER_ITEMS  = 16;

    // min first so the very first median is the most negative one
    localparam logic [rms_pkg::SAMPLE_W-1:0] CORNER_SAMPLES [CORNER_ITEMS] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
        32'hFFFF_FFFE, 32'h8000_0001, 32'h0000_0005, 32'h7FFF_FFFE
    };

    logic                                          clk;
    logic                                          rst_n;
    logic                                          s_tvalid;
    logic                                          s_tready;
    logic [rms_pkg::SAMPLE_W-1:0]                  s_tdata;
    logic                                          m_tvalid;
    logic                                          m_tready;
    logic [rms_pkg::MEDIAN_W+rms_pkg::COUNT_W-1:0] m_tdata;
    logic                                          m_tuser;

    int mismatch_count;
    int outstanding;
    int result_count;
    int drop_count;
    int idle_cycles = 0;
    int samples_sent = 0;
    bit steady = 1'b0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    running_median_sorted_insert #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    running_median_checker #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) median_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .result_count   (result_count),
        .drop_count     (drop_count)
    );

    // Mostly short gaps, a few long ones, none during steady stretches
    function automatic int gap_length();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [rms_pkg::SAMPLE_W-1:0] next_sample();
        int                           pick;
        logic [rms_pkg::SAMPLE_W-1:0] magnitude;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom;
        else if (pick < 65)
            return int'($urandom_range(0, 8)) - 4;   // dense duplicates
        else if (pick < 75)
            return 32'h8000_0000 + $urandom_range(0, 3);
        else if (pick < 85)
            return 32'h7FFF_FFFF - $urandom_range(0, 3);
        else
        begin
            magnitude = $urandom >> $urandom_range(0, 31);
            return $urandom_range(0, 1) ? -magnitude : magnitude;
        end
    endfunction

    task automatic send_sample(input logic [rms_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int run;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 24);
            m_tready = 1'b1;
            repeat (run) @(negedge clk);
            stall = gap_length();
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Ends the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     IDLE_LIMIT, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < CORNER_ITEMS; i++)
            send_sample(CORNER_SAMPLES[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n % 500) < 80;
            send_sample(next_sample());
        end
        steady   = 1'b0;
        s_tvalid = 1'b0;

        wait (outstanding == 0);
        repeat (CAPACITY + 8) @(posedge clk);

        $display("Sent %0d samples (%0d corner values, then random with duplicates).",
                 samples_sent, CORNER_ITEMS);
        $display("Checked %0d medians, %0d on a full store of %0d; %0d mismatches.",
                 result_count, drop_count, CAPACITY, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rms_pkg.sv
hw/rtl/rms_ram.sv
hw/rtl/rms_alu.sv
hw/rtl/running_median_sorted_insert.sv
bench/running_median_checker.sv
bench/running_median_sorted_insert_tb.sv
